/* rtl/core/rrdw_pkg.sv */
package rrdw_pkg;

  // Ring geometry and frame limits
  localparam int unsigned MAX_FRAME_BYTES = 1600;
  localparam int unsigned HDR_BYTES       = 4;
  localparam int unsigned ETH_HDR_BYTES   = 14;

  localparam logic [15:0] CNT_MIN = 16'(ETH_HDR_BYTES + HDR_BYTES);
  localparam logic [15:0] CNT_MAX = 16'(MAX_FRAME_BYTES + HDR_BYTES);
  localparam logic [15:0] HDR_LEN = 16'(HDR_BYTES);
  localparam logic [15:0] ETH_LEN = 16'(ETH_HDR_BYTES);

  // Reset values
  localparam logic [7:0] START_RST = 8'h46;
  localparam logic [7:0] STOP_RST  = 8'h80;
  localparam logic [7:0] NPP_RST   = 8'h47;

  // Ethertypes and status bits
  localparam logic [15:0] ETYPE_IP  = 16'h0800;
  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam int unsigned STAT_OK_BIT = 0;

  // Register map
  localparam logic REG_START = 1'b0;
  localparam logic REG_STOP  = 1'b1;

  typedef enum logic [2:0] {
    VERD_EMPTY     = 3'd0,
    VERD_BAD_HDR   = 3'd1,
    VERD_STAT_ERR  = 3'd2,
    VERD_SHORT     = 3'd3,
    VERD_IP        = 3'd4,
    VERD_ARP       = 3'd5,
    VERD_OTHER     = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [7:0] start_page;
    logic [7:0] stop_page;
  } ring_cfg_t;

  typedef struct packed {
    logic [7:0]  write_page;
    logic [7:0]  status;
    logic [7:0]  next_page;
    logic [15:0] byte_count;
    logic [15:0] frame_type;
  } hdr_req_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] seg1_addr;
    logic [10:0] seg1_len;
    logic [15:0] seg2_addr;
    logic [10:0] seg2_len;
    logic [7:0]  boundary_page;
    logic        rewrite_write_page;
  } walk_res_t;

endpackage

/* rtl/core/rrdw_cfg.sv */
module rrdw_cfg
  import rrdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output ring_cfg_t   cfg
);

  logic [7:0] start_r, start_nxt;
  logic [7:0] stop_r, stop_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode the write request
  always_comb begin
    start_nxt = start_r;
    stop_nxt  = stop_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_START: start_nxt = pwdata[7:0];
        REG_STOP:  stop_nxt  = pwdata[7:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      stop_r  <= STOP_RST;
    end else begin
      start_r <= start_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      REG_START: prdata = {24'd0, start_r};
      REG_STOP:  prdata = {24'd0, stop_r};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg.start_page = start_r;
  assign cfg.stop_page  = stop_r;

endmodule

/* rtl/core/rrdw_step.sv */
module rrdw_step
  import rrdw_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_BYTES
)
(
  input  ring_cfg_t  cfg,
  input  hdr_req_t   req,
  input  logic [7:0] npp,
  output walk_res_t  res,
  output logic [7:0] npp_nxt,
  output logic       err_inc,
  output logic       pkt_inc
);

  localparam logic [15:0] FRAME_CNT_MAX = 16'(MAX_FRAME + HDR_BYTES);

  logic        empty;
  logic        bad_hdr;
  logic [15:0] len;
  logic [7:0]  pages_left;
  logic [15:0] first;
  logic        split;
  logic [15:0] tail;
  logic [7:0]  bnry;

  // Empty ring and header sanity
  assign empty   = (npp == req.write_page);
  assign bad_hdr = (req.next_page < cfg.start_page) || (req.next_page >= cfg.stop_page) ||
                   (req.byte_count < CNT_MIN) || (req.byte_count > FRAME_CNT_MAX);

  // Segment split at the ring end
  assign len        = req.byte_count - HDR_LEN;
  assign pages_left = cfg.stop_page - npp;
  assign first      = {pages_left, 8'h00} - HDR_LEN;
  assign split      = (npp < cfg.stop_page) && (first < len);
  assign tail       = len - first;

  // Boundary trails the new page by one, wrapping to the ring end
  assign bnry = (req.next_page == cfg.start_page) ? (cfg.stop_page - 8'd1)
                                                  : (req.next_page - 8'd1);

  always_comb begin
    res     = '0;
    npp_nxt = npp;
    err_inc = 1'b0;
    pkt_inc = 1'b0;
    res.verdict = VERD_EMPTY;
    priority if (empty) begin
      res.verdict = VERD_EMPTY;
    end else if (bad_hdr) begin
      res.verdict            = VERD_BAD_HDR;
      res.boundary_page      = cfg.start_page;
      res.rewrite_write_page = 1'b1;
      npp_nxt                = cfg.start_page + 8'd1;
      err_inc                = 1'b1;
    end else begin
      res.seg1_addr     = {npp, 8'h00} + HDR_LEN;
      res.seg1_len      = split ? first[10:0] : len[10:0];
      res.seg2_addr     = split ? {cfg.start_page, 8'h00} : 16'd0;
      res.seg2_len      = split ? tail[10:0] : 11'd0;
      res.boundary_page = bnry;
      npp_nxt           = req.next_page;
      // Classify the frame
      priority if (!req.status[STAT_OK_BIT]) begin
        res.verdict = VERD_STAT_ERR;
        err_inc     = 1'b1;
      end else if (len <= ETH_LEN) begin
        res.verdict = VERD_SHORT;
        err_inc     = 1'b1;
      end else if (req.frame_type == ETYPE_IP) begin
        res.verdict = VERD_IP;
        pkt_inc     = 1'b1;
      end else if (req.frame_type == ETYPE_ARP) begin
        res.verdict = VERD_ARP;
        pkt_inc     = 1'b1;
      end else begin
        res.verdict = VERD_OTHER;
      end
    end
  end

endmodule

/* rtl/core/rrdw_core.sv */
module rrdw_core
  import rrdw_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_BYTES
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  ring_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  hdr_req_t    in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output walk_res_t   out_res,
  output logic [7:0]  out_npp,
  output logic [31:0] out_err,
  output logic [31:0] out_pkt
);

  logic        in_v_r;
  hdr_req_t    req_r;
  logic        out_v_r;
  walk_res_t   res_r;
  logic [7:0]  onpp_r;
  logic [31:0] oerr_r;
  logic [31:0] opkt_r;

  logic [7:0]  npp_r, npp_nxt;
  logic [31:0] err_r, err_nxt;
  logic [31:0] pkt_r, pkt_nxt;

  walk_res_t   res;
  logic [7:0]  step_npp;
  logic        err_inc;
  logic        pkt_inc;
  logic        out_free;
  logic        advance;

  assign out_free = !out_v_r || out_ready;
  assign advance  = in_v_r && out_free;
  assign in_ready = !in_v_r || out_free;

  rrdw_step #(
    .MAX_FRAME (MAX_FRAME)
  ) u_step (
    .cfg     (cfg),
    .req     (req_r),
    .npp     (npp_r),
    .res     (res),
    .npp_nxt (step_npp),
    .err_inc (err_inc),
    .pkt_inc (pkt_inc)
  );

  // Walker state moves only when a request leaves the input register
  assign npp_nxt = advance ? step_npp : npp_r;
  assign err_nxt = (advance && err_inc) ? err_r + 32'd1 : err_r;
  assign pkt_nxt = (advance && pkt_inc) ? pkt_r + 32'd1 : pkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      npp_r   <= NPP_RST;
      err_r   <= 32'd0;
      pkt_r   <= 32'd0;
    end else begin
      npp_r <= npp_nxt;
      err_r <= err_nxt;
      pkt_r <= pkt_nxt;
      // Input register: take a request whenever the slot empties
      if (in_valid && in_ready) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      // Result register: hold until taken
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
    if (advance) begin
      res_r  <= res;
      onpp_r <= npp_nxt;
      oerr_r <= err_nxt;
      opkt_r <= pkt_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = res_r;
  assign out_npp   = onpp_r;
  assign out_err   = oerr_r;
  assign out_pkt   = opkt_r;

endmodule

/* rtl/core/receive_ring_descriptor_walker.sv */
// Receive ring descriptor walker.
// Input channel (in_*): one request per received packet, carrying the
// receiver's write page, the 4-byte header read at the walker's own
// next-packet page, and the frame's ethertype. Result channel (out_*): one
// result per request with the verdict, one or two read segments split at
// the ring end, the boundary page to write, the write-page rewrite flag,
// the new next-packet page and the running error and packet counts.
// Ring start and stop pages are set through the APB port (start at byte
// address 0, stop at 4); the user must set them only while no request is
// in flight, as the block itself does not enforce this. Throughput: one
// request per cycle while the receiver takes results. The walk is a single
// compare/subtract pass between the input register and the result
// register.
// Reset: start 0x46, stop 0x80, next-packet page 0x47, counts cleared,
// both registers empty.
// When the receiver stalls the result register holds; one more request
// waits in the input register, then in_ready drops.
module receive_ring_descriptor_walker
  import rrdw_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_BYTES
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_write_page,
  input  logic [7:0]  in_header_status,
  input  logic [7:0]  in_header_next_page,
  input  logic [15:0] in_header_byte_count,
  input  logic [15:0] in_frame_ether_type,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [15:0] out_seg1_addr,
  output logic [10:0] out_seg1_len,
  output logic [15:0] out_seg2_addr,
  output logic [10:0] out_seg2_len,
  output logic [7:0]  out_boundary_page,
  output logic        out_rewrite_write_page,
  output logic [7:0]  out_next_page,
  output logic [31:0] out_error_count,
  output logic [31:0] out_packet_count
);

  ring_cfg_t cfg;
  hdr_req_t  in_req;
  walk_res_t res;

  rrdw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pack the request
  assign in_req.write_page = in_write_page;
  assign in_req.status     = in_header_status;
  assign in_req.next_page  = in_header_next_page;
  assign in_req.byte_count = in_header_byte_count;
  assign in_req.frame_type = in_frame_ether_type;

  rrdw_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_npp   (out_next_page),
    .out_err   (out_error_count),
    .out_pkt   (out_packet_count)
  );

  // Unpack the result
  assign out_verdict            = 3'(res.verdict);
  assign out_seg1_addr          = res.seg1_addr;
  assign out_seg1_len           = res.seg1_len;
  assign out_seg2_addr          = res.seg2_addr;
  assign out_seg2_len           = res.seg2_len;
  assign out_boundary_page      = res.boundary_page;
  assign out_rewrite_write_page = res.rewrite_write_page;

endmodule

/* test/receive_ring_descriptor_walker_test.sv */
module receive_ring_descriptor_walker_test;
  import rrdw_pkg::*;

  localparam int NUM_SETTINGS = 9;

  // Expected walk result, counts included
  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] seg1_addr;
    logic [10:0] seg1_len;
    logic [15:0] seg2_addr;
    logic [10:0] seg2_len;
    logic [7:0]  boundary_page;
    logic        rewrite_write_page;
    logic [7:0]  next_page;
    logic [31:0] error_count;
    logic [31:0] packet_count;
  } walk_expect_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_write_page;
  logic [7:0]  in_header_status;
  logic [7:0]  in_header_next_page;
  logic [15:0] in_header_byte_count;
  logic [15:0] in_frame_ether_type;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_verdict;
  logic [15:0] out_seg1_addr;
  logic [10:0] out_seg1_len;
  logic [15:0] out_seg2_addr;
  logic [10:0] out_seg2_len;
  logic [7:0]  out_boundary_page;
  logic        out_rewrite_write_page;
  logic [7:0]  out_next_page;
  logic [31:0] out_error_count;
  logic [31:0] out_packet_count;

  // Ring walk state mirrored by the testbench
  logic [7:0]  ring_start;
  logic [7:0]  ring_stop;
  logic [7:0]  walk_page;
  logic [31:0] error_total;
  logic [31:0] packet_total;

  walk_expect_t pending_results[$];
  int          mismatches;
  int          requests_sent;
  int          wrapped_frames;
  int          settings_run;
  int          verdict_seen [8];
  bit          source_gaps;
  bit          sink_stalls;

  // Ring settings for the sweep: normal, one page, small, full, top, start above or at stop
  logic [7:0] sweep_start [NUM_SETTINGS] =
    '{8'h46, 8'h00, 8'h10, 8'h00, 8'hFE, 8'hC0, 8'hFF, 8'h30, 8'h46};
  logic [7:0] sweep_stop  [NUM_SETTINGS] =
    '{8'h80, 8'h01, 8'h14, 8'hFF, 8'hFF, 8'h20, 8'h01, 8'h30, 8'h80};
  int         sweep_items [NUM_SETTINGS] =
    '{150, 100, 150, 150, 100, 40, 40, 40, 180};

  receive_ring_descriptor_walker u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d results outstanding", pending_results.size());
    $display("receive_ring_descriptor_walker_test NOT OK");
    $finish;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Walk one header against the mirrored ring state and advance it
  function automatic walk_expect_t walk_ring(hdr_req_t req);
    walk_expect_t want;
    int unsigned  frame_len;
    int unsigned  first_len;
    bit           split;
    want = '0;
    want.verdict = VERD_EMPTY;
    if (walk_page == req.write_page) begin
      want.verdict = VERD_EMPTY;
    end else if (req.next_page < ring_start || req.next_page >= ring_stop ||
                 req.byte_count < CNT_MIN || req.byte_count > CNT_MAX) begin
      error_total++;
      walk_page = ring_start + 8'd1;
      want.boundary_page = ring_start;
      want.rewrite_write_page = 1'b1;
      want.verdict = VERD_BAD_HDR;
    end else begin
      frame_len = int'(req.byte_count) - int'(HDR_BYTES);
      split = 1'b0;
      first_len = 0;
      // split where the frame runs past the ring end
      if (walk_page < ring_stop) begin
        first_len = (int'(ring_stop) - int'(walk_page)) * 256 - int'(HDR_BYTES);
        split = first_len < frame_len;
      end
      want.seg1_addr = {walk_page, 8'h00} + HDR_LEN;
      if (split) begin
        wrapped_frames++;
        want.seg1_len  = 11'(first_len);
        want.seg2_addr = {ring_start, 8'h00};
        want.seg2_len  = 11'(frame_len - first_len);
      end else begin
        want.seg1_len = 11'(frame_len);
      end
      walk_page = req.next_page;
      want.boundary_page = (req.next_page == ring_start) ? ring_stop - 8'd1
                                                         : req.next_page - 8'd1;
      // classify the frame
      if (!req.status[STAT_OK_BIT]) begin
        error_total++;
        want.verdict = VERD_STAT_ERR;
      end else if (frame_len <= ETH_HDR_BYTES) begin
        error_total++;
        want.verdict = VERD_SHORT;
      end else if (req.frame_type == ETYPE_IP) begin
        packet_total++;
        want.verdict = VERD_IP;
      end else if (req.frame_type == ETYPE_ARP) begin
        packet_total++;
        want.verdict = VERD_ARP;
      end else begin
        want.verdict = VERD_OTHER;
      end
    end
    want.next_page = walk_page;
    want.error_count = error_total;
    want.packet_count = packet_total;
    return want;
  endfunction

  // Any bit pattern: mostly bad headers, some empty-ring requests
  function automatic hdr_req_t noisy_frame();
    hdr_req_t req;
    req = 56'({$urandom, $urandom});
    if ($urandom_range(0, 2) == 0) req.write_page = walk_page;
    return req;
  endfunction

  // Header that passes the bounds check, biased toward the ring end; noisy if start is not below stop
  function automatic hdr_req_t well_formed_frame();
    hdr_req_t    req;
    int unsigned span;
    int unsigned roll;
    if (ring_start >= ring_stop) return noisy_frame();
    span = int'(ring_stop) - int'(ring_start);
    req.write_page = walk_page + 8'($urandom_range(1, 255));
    req.status = {7'($urandom), 1'b1};
    if ($urandom_range(0, 99) < 12) req.status[STAT_OK_BIT] = 1'b0;
    if ($urandom_range(0, 1) == 1)
      req.next_page = ring_stop - 8'd1 - 8'($urandom_range(0, (span > 4) ? 3 : span - 1));
    else
      req.next_page = ring_start + 8'($urandom_range(0, span - 1));
    roll = $urandom_range(0, 99);
    if (roll < 20) req.byte_count = 16'($urandom_range(CNT_MIN, CNT_MIN + 16));
    else if (roll < 80) req.byte_count = 16'($urandom_range(CNT_MIN + 17, CNT_MAX));
    else req.byte_count = 16'($urandom_range(CNT_MAX - 200, CNT_MAX));
    roll = $urandom_range(0, 99);
    if (roll < 40) req.frame_type = ETYPE_IP;
    else if (roll < 70) req.frame_type = ETYPE_ARP;
    else req.frame_type = 16'($urandom);
    return req;
  endfunction

  // Drive one request, hold it until accepted, then record its result
  task automatic send_request(input hdr_req_t req);
    int unsigned gap;
    @(negedge clk);
    in_valid             <= 1'b1;
    in_write_page        <= req.write_page;
    in_header_status     <= req.status;
    in_header_next_page  <= req.next_page;
    in_header_byte_count <= req.byte_count;
    in_frame_ether_type  <= req.frame_type;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(walk_ring(req));
    requests_sent++;
    gap = source_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_ring_reg(input logic idx, input logic [7:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== want) begin
      $display("%0t: register %0d expected 0x%0h, got 0x%0h", $time, idx, want, prdata[7:0]);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_ring_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_START) ring_start = value;
    else ring_stop = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_ring_reg(idx, value);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    walk_expect_t want;
    if (rst_n && out_valid && out_ready) begin
      verdict_seen[out_verdict]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, verdict %0d", $time, out_verdict);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("verdict", 32'(want.verdict), 32'(out_verdict));
        check_field("seg1_addr", 32'(want.seg1_addr), 32'(out_seg1_addr));
        check_field("seg1_len", 32'(want.seg1_len), 32'(out_seg1_len));
        check_field("seg2_addr", 32'(want.seg2_addr), 32'(out_seg2_addr));
        check_field("seg2_len", 32'(want.seg2_len), 32'(out_seg2_len));
        check_field("boundary_page", 32'(want.boundary_page), 32'(out_boundary_page));
        check_field("rewrite_write_page", 32'(want.rewrite_write_page),
                    32'(out_rewrite_write_page));
        check_field("next_page", 32'(want.next_page), 32'(out_next_page));
        check_field("error_count", want.error_count, out_error_count);
        check_field("packet_count", want.packet_count, out_packet_count);
      end
    end
  end

  // Stall the result side at random
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && sink_stalls && $urandom_range(0, 3) == 0) hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_register_reset();
    check_ring_reg(REG_START, START_RST);
    check_ring_reg(REG_STOP, STOP_RST);
  endtask

  // Fields: write page, status, next page, byte count, ethertype
  task automatic test_empty_and_bad_headers();
    send_request({8'h47, 8'h01, 8'h50, 16'd100, ETYPE_IP});
    send_request({8'h60, 8'h01, 8'h45, 16'd100, ETYPE_IP});
    send_request({8'h60, 8'h01, 8'h80, 16'd100, ETYPE_IP});
    send_request({8'h60, 8'h01, 8'h50, CNT_MIN - 16'd1, ETYPE_IP});
    send_request({8'h60, 8'h01, 8'h50, CNT_MAX + 16'd1, ETYPE_IP});
  endtask

  task automatic test_frame_classes();
    send_request({8'h60, 8'h01, 8'h50, CNT_MIN, ETYPE_IP});
    send_request({8'h60, 8'h01, 8'h52, CNT_MIN + 16'd1, ETYPE_IP});
    send_request({8'h60, 8'h01, 8'h55, 16'd64, ETYPE_ARP});
    send_request({8'h60, 8'h01, 8'h58, 16'd64, 16'h86DD});
    send_request({8'h60, 8'h00, 8'h5A, 16'd64, ETYPE_IP});
    send_request({8'h60, 8'hFE, 8'h5C, 16'd64, ETYPE_IP});
    send_request({8'h60, 8'hFF, 8'h63, CNT_MAX, ETYPE_IP});
  endtask

  // Reach the last page, wrap a full frame onto ring start, fit the ring end exactly, split by one byte
  task automatic test_ring_wrap();
    send_request({8'h60, 8'h01, 8'h7F, 16'd64, ETYPE_IP});
    send_request({8'h60, 8'h01, 8'h46, CNT_MAX, ETYPE_ARP});
    send_request({8'h60, 8'h01, 8'h7E, 16'd600, ETYPE_IP});
    send_request({8'h60, 8'h01, 8'h7F, 16'd512, ETYPE_IP});
    send_request({8'h60, 8'h01, 8'h47, 16'd257, ETYPE_IP});
  endtask

  task automatic test_field_extremes();
    send_request({8'h00, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF});
    send_request({8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000});
    send_request({8'hFF, 8'h01, 8'h48, 16'd200, 16'h0000});
  endtask

  // Random requests under each ring setting, pausing for the results now and then
  task automatic test_setting_sweep();
    bit [1:0] mode;
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_idle();
      write_ring_reg(REG_START, sweep_start[s]);
      write_ring_reg(REG_STOP, sweep_stop[s]);
      settings_run++;
      mode = 2'($urandom_range(0, 3));
      source_gaps = mode[0];
      sink_stalls = mode[1];
      send_request(well_formed_frame());
      for (int n = 1; n < sweep_items[s]; n++) begin
        if ($urandom_range(0, 99) < 75) send_request(well_formed_frame());
        else send_request(noisy_frame());
        if (n % 60 == 0) wait_idle();
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_valid             = 1'b0;
    in_write_page        = '0;
    in_header_status     = '0;
    in_header_next_page  = '0;
    in_header_byte_count = '0;
    in_frame_ether_type  = '0;
    ring_start           = START_RST;
    ring_stop            = STOP_RST;
    walk_page            = NPP_RST;
    error_total          = '0;
    packet_total         = '0;
    source_gaps          = 1'b1;
    sink_stalls          = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_reset();
    test_empty_and_bad_headers();
    test_frame_classes();
    test_ring_wrap();
    test_field_extremes();
    test_setting_sweep();
    wait_idle();

    $display("Walked %0d requests over %0d ring settings; %0d frames wrapped the ring end.",
             requests_sent, settings_run, wrapped_frames);
    $display({"Verdicts: empty %0d, bad header %0d, status error %0d, short %0d, ",
              "IP %0d, ARP %0d, other %0d"},
             verdict_seen[VERD_EMPTY], verdict_seen[VERD_BAD_HDR], verdict_seen[VERD_STAT_ERR],
             verdict_seen[VERD_SHORT], verdict_seen[VERD_IP], verdict_seen[VERD_ARP],
             verdict_seen[VERD_OTHER]);
    if (mismatches == 0)
      $display("receive_ring_descriptor_walker_test OK");
    else
      $display("receive_ring_descriptor_walker_test NOT OK");
    $finish;
  end

endmodule
